// File: src/srpt_pkg.sv
// shared types and constants for the sync relative photon tagger
package srpt_pkg;

   // fixed field widths
   localparam int CHAN_W  = 8;
   localparam int STAMP_W = 48;
   localparam int PULSE_W = 48;

   // input command codes
   localparam logic CMD_PHOTON = 1'b0;
   localparam logic CMD_FLUSH  = 1'b1;

   // operations passed from the front end to the back end
   typedef enum logic [1:0] {
      OP_PUSH  = 2'd0,
      OP_FIRST = 2'd1,
      OP_SYNC  = 2'd2,
      OP_FLUSH = 2'd3
   } srpt_op_type;

   // one entry of the command queue
   typedef struct packed {
      srpt_op_type        op;
      logic [CHAN_W-1:0]  chan;
      logic [STAMP_W-1:0] stamp;
   } srpt_cmd_type;

endpackage

// File: src/srpt_ram.sv
// generic single write port ram with registered read
module srpt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read, holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: src/srpt_front.sv
// front end: takes input beats, classifies them and queues operations
module srpt_front #(
   parameter int QUEUE_DEPTH = 64
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [srpt_pkg::CHAN_W-1:0]      csr_sync_channel,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_cmd,
   input  logic [srpt_pkg::CHAN_W-1:0]      req_channel,
   input  logic [srpt_pkg::STAMP_W-1:0]     req_time_req,
   input  logic                             fifo_full,
   output logic                             push,
   output srpt_pkg::srpt_cmd_type           push_data
);

   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   logic [srpt_pkg::CHAN_W-1:0] sync_chan_ff, sync_chan_in;
   logic                        first_seen_ff, first_seen_in;
   logic [CW-1:0]               occ_ff, occ_in;
   logic                        accept;

   assign csr_ready = 1'b1;
   assign req_stall = fifo_full;
   assign accept    = req_valid && !req_stall;

   // classify the beat against the predicted store occupancy
   always_comb begin
      sync_chan_in    = sync_chan_ff;
      first_seen_in   = first_seen_ff;
      occ_in          = occ_ff;
      push            = 1'b0;
      push_data.op    = srpt_pkg::OP_PUSH;
      push_data.chan  = req_channel;
      push_data.stamp = req_time_req;
      if (csr_valid) begin
         sync_chan_in = csr_sync_channel;
      end
      if (accept) begin
         if (req_cmd == srpt_pkg::CMD_FLUSH) begin
            push          = 1'b1;
            push_data.op  = srpt_pkg::OP_FLUSH;
            first_seen_in = 1'b0;
            occ_in        = '0;
         end else if (req_channel == sync_chan_ff) begin
            push = 1'b1;
            if (first_seen_ff) begin
               push_data.op = srpt_pkg::OP_SYNC;
               occ_in       = '0;
            end else begin
               push_data.op  = srpt_pkg::OP_FIRST;
               first_seen_in = 1'b1;
            end
         end else if (first_seen_ff && (occ_ff < CW'(QUEUE_DEPTH))) begin
            push         = 1'b1;
            push_data.op = srpt_pkg::OP_PUSH;
            occ_in       = occ_ff + 1'b1;
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         sync_chan_ff  <= '0;
         first_seen_ff <= 1'b0;
         occ_ff        <= '0;
      end else begin
         sync_chan_ff  <= sync_chan_in;
         first_seen_ff <= first_seen_in;
         occ_ff        <= occ_in;
      end
   end

endmodule

// File: src/srpt_cmd_fifo.sv
// two entry operation queue between front end and back end
module srpt_cmd_fifo (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  srpt_pkg::srpt_cmd_type push_data,
   output logic                   full,
   input  logic                   pop,
   output srpt_pkg::srpt_cmd_type pop_data,
   output logic                   empty
);

   srpt_pkg::srpt_cmd_type entry_ff [2];
   logic                   wr_ptr_ff, wr_ptr_in;
   logic                   rd_ptr_ff, rd_ptr_in;
   logic [1:0]             count_ff, count_in;

   assign full     = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign pop_data = entry_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   // queue never overflows or underflows
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      (push && full) |-> pop)
      else $error("operation queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty)
      else $error("operation queue underflow");

endmodule

// File: src/srpt_back.sv
// back end: photon store, burst drain and result register
module srpt_back #(
   parameter int QUEUE_DEPTH = 64,
   parameter int TIME_BITS   = 48
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            cmd_empty,
   input  srpt_pkg::srpt_cmd_type          cmd_data,
   output logic                            cmd_pop,
   input  logic                            rsp_stall,
   output logic                            rsp_valid,
   output logic [srpt_pkg::CHAN_W-1:0]     rsp_photon_channel,
   output logic [srpt_pkg::PULSE_W-1:0]    rsp_pulse,
   output logic [srpt_pkg::STAMP_W-1:0]    rsp_rel_time,
   output logic                            rsp_last
);

   localparam int TW = (TIME_BITS < srpt_pkg::STAMP_W) ? TIME_BITS : srpt_pkg::STAMP_W;
   localparam int AW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);
   localparam int EW = srpt_pkg::CHAN_W + TW;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_READ = 3'b010,
      S_LOAD = 3'b100
   } srpt_state_type;

   srpt_state_type               state_ff, state_in;
   logic [AW-1:0]                head_ff, head_in;
   logic [AW-1:0]                tail_ff, tail_in;
   logic [CW-1:0]                count_ff, count_in;
   logic [TW-1:0]                ref_ff, ref_in;
   logic [srpt_pkg::PULSE_W-1:0] pulse_ff, pulse_in;
   srpt_pkg::srpt_op_type        pend_op_ff, pend_op_in;
   logic [TW-1:0]                pend_time_ff, pend_time_in;
   logic                         last_pend_ff, last_pend_in;

   logic                         rsp_valid_ff, rsp_valid_in;
   logic [srpt_pkg::CHAN_W-1:0]  rsp_chan_ff, rsp_chan_in;
   logic [srpt_pkg::PULSE_W-1:0] rsp_pulse_ff, rsp_pulse_in;
   logic [srpt_pkg::STAMP_W-1:0] rsp_rel_ff, rsp_rel_in;
   logic                         rsp_last_ff, rsp_last_in;

   logic                         ram_we;
   logic                         ram_re;
   logic [EW-1:0]                ram_wdata;
   logic [EW-1:0]                ram_rdata;
   logic [TW-1:0]                rel_diff;
   logic                         out_free;
   logic                         end_go;
   srpt_pkg::srpt_op_type        end_op;
   logic [TW-1:0]                end_time;

   function automatic logic [AW-1:0] ptr_next(input logic [AW-1:0] p);
      ptr_next = (p == AW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   // photon store
   srpt_ram #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (tail_ff),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (head_ff),
      .rd_data (ram_rdata)
   );

   assign ram_wdata = {cmd_data.chan, cmd_data.stamp[TW-1:0]};
   assign rel_diff  = ram_rdata[TW-1:0] - ref_ff;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // sequencer: store photons, drain bursts, apply sync and flush
   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      ref_in       = ref_ff;
      pulse_in     = pulse_ff;
      pend_op_in   = pend_op_ff;
      pend_time_in = pend_time_ff;
      last_pend_in = last_pend_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_chan_in  = rsp_chan_ff;
      rsp_pulse_in = rsp_pulse_ff;
      rsp_rel_in   = rsp_rel_ff;
      rsp_last_in  = rsp_last_ff;
      ram_we       = 1'b0;
      ram_re       = 1'b0;
      cmd_pop      = 1'b0;
      end_go       = 1'b0;
      end_op       = pend_op_ff;
      end_time     = pend_time_ff;
      case (state_ff)
         S_IDLE: begin
            if (!cmd_empty) begin
               cmd_pop = 1'b1;
               case (cmd_data.op)
                  srpt_pkg::OP_PUSH: begin
                     ram_we   = 1'b1;
                     tail_in  = ptr_next(tail_ff);
                     count_in = count_ff + 1'b1;
                  end
                  srpt_pkg::OP_FIRST: begin
                     ref_in   = cmd_data.stamp[TW-1:0];
                     pulse_in = '0;
                  end
                  srpt_pkg::OP_SYNC, srpt_pkg::OP_FLUSH: begin
                     if (count_ff == '0) begin
                        end_go   = 1'b1;
                        end_op   = cmd_data.op;
                        end_time = cmd_data.stamp[TW-1:0];
                     end else begin
                        pend_op_in   = cmd_data.op;
                        pend_time_in = cmd_data.stamp[TW-1:0];
                        state_in     = S_READ;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_READ: begin
            ram_re       = 1'b1;
            head_in      = ptr_next(head_ff);
            count_in     = count_ff - 1'b1;
            last_pend_in = (count_ff == CW'(1));
            state_in     = S_LOAD;
         end
         S_LOAD: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_chan_in  = ram_rdata[EW-1:TW];
               rsp_pulse_in = pulse_ff;
               rsp_rel_in   = srpt_pkg::STAMP_W'(rel_diff);
               rsp_last_in  = last_pend_ff;
               if (last_pend_ff) begin
                  end_go   = 1'b1;
                  state_in = S_IDLE;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      // end of burst or of an empty sync or flush: move the reference and count the pulse, or return to the reset state
      if (end_go) begin
         if (end_op == srpt_pkg::OP_FLUSH) begin
            head_in  = '0;
            tail_in  = '0;
            count_in = '0;
            ref_in   = '0;
            pulse_in = '0;
         end else begin
            ref_in   = end_time;
            pulse_in = pulse_ff + 1'b1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         ref_ff       <= '0;
         pulse_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         count_ff     <= count_in;
         ref_ff       <= ref_in;
         pulse_ff     <= pulse_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      pend_op_ff   <= pend_op_in;
      pend_time_ff <= pend_time_in;
      last_pend_ff <= last_pend_in;
      rsp_chan_ff  <= rsp_chan_in;
      rsp_pulse_ff <= rsp_pulse_in;
      rsp_rel_ff   <= rsp_rel_in;
      rsp_last_ff  <= rsp_last_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_photon_channel = rsp_chan_ff;
   assign rsp_pulse          = rsp_pulse_ff;
   assign rsp_rel_time       = rsp_rel_ff;
   assign rsp_last           = rsp_last_ff;

   // store occupancy stays in range
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(QUEUE_DEPTH))
      else $error("photon store count out of range");
   // a read is only issued with photons held
   a_read_nonempty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_READ) |-> (count_ff != '0))
      else $error("store read while empty");
   // the marked beat leaves the store empty
   a_last_empty: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_LOAD && out_free && last_pend_ff) |-> (count_ff == '0))
      else $error("last beat with photons still stored");
   // pointers meet whenever the store is empty
   a_ptr_meet: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (head_ff == tail_ff))
      else $error("pointers differ on empty store");

endmodule

// File: src/sync_relative_photon_tagger.sv
// top level of the sync relative photon tagger: front end, operation queue and back end
// with photons stored, a sync or flush beat goes via the queue, S_READ and S_LOAD to a result
// throughput: one input beat a cycle while the two entry operation queue has room
// a burst alternates S_READ and S_LOAD per result, as the store has one registered read port
// the input stalls once the operation queue fills behind a draining burst
// reset: synchronous, active high; clears pointers, counts, reference, pulse, sync channel
module sync_relative_photon_tagger #(
   parameter int QUEUE_DEPTH = 64,
   parameter int TIME_BITS   = 48
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [srpt_pkg::CHAN_W-1:0]  csr_sync_channel,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  logic                         req_cmd,
   input  logic [srpt_pkg::CHAN_W-1:0]  req_channel,
   input  logic [srpt_pkg::STAMP_W-1:0] req_time_req,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output logic [srpt_pkg::CHAN_W-1:0]  rsp_photon_channel,
   output logic [srpt_pkg::PULSE_W-1:0] rsp_pulse,
   output logic [srpt_pkg::STAMP_W-1:0] rsp_rel_time,
   output logic                         rsp_last
);

   logic                   fifo_full;
   logic                   fifo_empty;
   logic                   fifo_push;
   logic                   fifo_pop;
   srpt_pkg::srpt_cmd_type fifo_wdata;
   srpt_pkg::srpt_cmd_type fifo_rdata;

   // classify incoming beats
   srpt_front #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_sync_channel (csr_sync_channel),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_cmd          (req_cmd),
      .req_channel      (req_channel),
      .req_time_req     (req_time_req),
      .fifo_full        (fifo_full),
      .push             (fifo_push),
      .push_data        (fifo_wdata)
   );

   // operation queue
   srpt_cmd_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (fifo_push),
      .push_data (fifo_wdata),
      .full      (fifo_full),
      .pop       (fifo_pop),
      .pop_data  (fifo_rdata),
      .empty     (fifo_empty)
   );

   // store and drain
   srpt_back #(
      .QUEUE_DEPTH (QUEUE_DEPTH),
      .TIME_BITS   (TIME_BITS)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .cmd_empty          (fifo_empty),
      .cmd_data           (fifo_rdata),
      .cmd_pop            (fifo_pop),
      .rsp_stall          (rsp_stall),
      .rsp_valid          (rsp_valid),
      .rsp_photon_channel (rsp_photon_channel),
      .rsp_pulse          (rsp_pulse),
      .rsp_rel_time       (rsp_rel_time),
      .rsp_last           (rsp_last)
   );

endmodule
